### hw/rtl/dop_pkg.sv
// dop_pkg: shared types and option codes for the dhcp option parser
// no dependencies; imported by every module of the block
`default_nettype none

package dop_pkg;

   // option codes
   localparam logic [7:0] OPT_PAD       = 8'd0;
   localparam logic [7:0] OPT_MASK      = 8'd1;
   localparam logic [7:0] OPT_ROUTER    = 8'd3;
   localparam logic [7:0] OPT_DNS       = 8'd6;
   localparam logic [7:0] OPT_BCAST     = 8'd28;
   localparam logic [7:0] OPT_DHCP_TYPE = 8'd53;
   localparam logic [7:0] OPT_SERVER    = 8'd54;
   localparam logic [7:0] OPT_END       = 8'd255;

   // message type when none present
   localparam logic [7:0] TYPE_NONE     = 8'd255;

   // result status codes
   localparam logic STATUS_END_SEEN  = 1'b0;
   localparam logic STATUS_TRUNCATED = 1'b1;

   // bytes of an address value
   localparam logic [2:0] ADDR_BYTES = 3'd4;

   typedef enum logic [1:0] {
      PH_CODE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  opt_byte;
      logic        start_req;
      logic        frame_end;
      logic [31:0] your_ip;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  message_type;
      logic [31:0] client_ip;
      logic [31:0] server_ip;
      logic [31:0] subnet_mask;
      logic [31:0] broadcast_ip;
      logic [31:0] router_ip;
      logic [31:0] dns_ip;
   } rsp_type;

   // action word passed from the front walker to the back end
   typedef struct packed {
      logic        start;
      logic [31:0] ip;
      logic        set_type;
      logic [7:0]  type_val;
      logic        commit;
      logic [7:0]  code;
      logic [31:0] value;
      logic        emit;
      logic        status;
   } cmd_type;

endpackage

`default_nettype wire

### hw/rtl/dhcp_option_parser.sv
// dhcp_option_parser: top level of the dhcp reply options walker
// depends on dop_pkg, dop_front, dop_queue, dop_back
//
//   channel  | direction | handshake          | word
//   req_     | in        | req_valid/ready    | one options byte plus start/end marks
//   rsp_     | out       | rsp_valid/ready    | one result per message
//
// one byte is taken per cycle while the queue has room; the front walker updates its state in that cycle.
// a result passes from the walker through the queue word and then the result register.
// the queue (QueueDepth words) lets the walker keep taking bytes while a result waits.
// reset is synchronous and clears the walker, the queue and all held addresses.
// req_ready drops only when the queue is full, i.e. after a long rsp_ready stall.
`default_nettype none

module dhcp_option_parser #(
   parameter int QueueDepth = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  dop_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output dop_pkg::rsp_type    rsp_data
);
   import dop_pkg::*;

   logic    push, push_ready, pop, pop_valid;
   cmd_type push_data, pop_data;

   // record walker
   dop_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_ready   (push_ready),
      .cmd_valid (push),
      .cmd_data  (push_data)
   );

   // action queue
   dop_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // held values and result register
   dop_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_data  (pop_data),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/dop_front.sv
// dop_front: walks code/length/value records one byte per cycle while the queue has room
// depends on dop_pkg; pushes action words into dop_queue
`default_nettype none

module dop_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  dop_pkg::req_type    req_data,
   input  wire                 q_ready,
   output logic                cmd_valid,
   output dop_pkg::cmd_type    cmd_data
);
   import dop_pkg::*;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [7:0]  code_ff, code_in, code_cur;
   logic [7:0]  left_ff, left_in, left_cur;
   logic [2:0]  pos_ff, pos_in, pos_cur;
   logic [31:0] shift_ff, shift_in, shift_cur;
   logic        closed_ff, closed_in, closed_cur;
   logic        ended;
   logic        accept;
   logic        need;
   logic [7:0]  b;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign b         = req_data.opt_byte;

   // per-byte record walk
   always_comb begin
      phase_cur  = req_data.start_req ? PH_CODE : phase_ff;
      code_cur   = req_data.start_req ? 8'd0    : code_ff;
      left_cur   = req_data.start_req ? 8'd0    : left_ff;
      pos_cur    = req_data.start_req ? 3'd0    : pos_ff;
      shift_cur  = req_data.start_req ? 32'd0   : shift_ff;
      closed_cur = req_data.start_req ? 1'b0    : closed_ff;

      phase_in  = phase_cur;
      code_in   = code_cur;
      left_in   = left_cur;
      pos_in    = pos_cur;
      shift_in  = shift_cur;
      closed_in = closed_cur;
      ended     = 1'b0;

      cmd_data          = '0;
      cmd_data.start    = req_data.start_req;
      cmd_data.ip       = req_data.your_ip;
      cmd_data.type_val = b;
      cmd_data.code     = code_cur;

      if (!closed_cur) begin
         case (phase_cur)
            PH_LEN: begin
               left_in  = b;
               pos_in   = 3'd0;
               shift_in = 32'd0;
               phase_in = (b == OPT_PAD) ? PH_CODE : PH_VALUE;
            end
            PH_VALUE: begin
               if (pos_cur < ADDR_BYTES) begin
                  if (pos_cur == 3'd0 && code_cur == OPT_DHCP_TYPE) begin
                     cmd_data.set_type = 1'b1;
                  end
                  shift_in = {shift_cur[23:0], b};
                  pos_in   = pos_cur + 3'd1;
                  if (pos_in == ADDR_BYTES) begin
                     cmd_data.commit = 1'b1;
                  end
               end
               left_in = left_cur - 8'd1;
               if (left_in == 8'd0) begin
                  phase_in = PH_CODE;
               end
            end
            default: begin
               if (b == OPT_END) begin
                  closed_in       = 1'b1;
                  phase_in        = PH_CODE;
                  ended           = 1'b1;
                  cmd_data.emit   = 1'b1;
                  cmd_data.status = STATUS_END_SEEN;
               end else if (b != OPT_PAD) begin
                  code_in  = b;
                  phase_in = PH_LEN;
               end
            end
         endcase

         // last byte of the area without an end code
         if (!ended && req_data.frame_end) begin
            closed_in       = 1'b1;
            phase_in        = PH_CODE;
            cmd_data.emit   = 1'b1;
            cmd_data.status = STATUS_TRUNCATED;
         end
      end

      cmd_data.value = shift_in;
      need      = cmd_data.start | cmd_data.set_type | cmd_data.commit | cmd_data.emit;
      cmd_valid = accept && need;
   end

   // walker state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CODE;
         code_ff   <= 8'd0;
         left_ff   <= 8'd0;
         pos_ff    <= 3'd0;
         shift_ff  <= 32'd0;
         closed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         shift_ff  <= shift_in;
         closed_ff <= closed_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dop_queue.sv
// dop_queue: small first-in first-out queue of action words
// depends on dop_pkg; sits between dop_front and dop_back
`default_nettype none

module dop_queue #(
   parameter int Depth = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  dop_pkg::cmd_type    push_data,
   output logic                push_ready,
   input  wire                 pop,
   output logic                pop_valid,
   output dop_pkg::cmd_type    pop_data
);
   import dop_pkg::*;

   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   cmd_type       entry_ff [Depth];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(Depth - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(Depth - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dop_back.sv
// dop_back: applies action words to the held values and issues results
// depends on dop_pkg; fed by dop_queue, drives the result channel
`default_nettype none

module dop_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   input  dop_pkg::cmd_type    cmd_data,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output dop_pkg::rsp_type    rsp_data
);
   import dop_pkg::*;

   logic [31:0] ip_ff, ip_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] server_ff, server_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] bcast_ff, bcast_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] dns_ff, dns_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // take a word unless it emits into a full output register that rsp_ready is not draining
   assign cmd_pop   = cmd_valid && (!cmd_data.emit || !rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // held values after this word
   always_comb begin
      ip_in     = cmd_data.start ? cmd_data.ip : ip_ff;
      type_in   = cmd_data.start ? TYPE_NONE   : type_ff;
      server_in = server_ff;
      mask_in   = mask_ff;
      bcast_in  = bcast_ff;
      router_in = router_ff;
      dns_in    = dns_ff;
      if (cmd_data.set_type) begin
         type_in = cmd_data.type_val;
      end
      if (cmd_data.commit) begin
         case (cmd_data.code)
            OPT_MASK:   mask_in   = cmd_data.value;
            OPT_ROUTER: router_in = cmd_data.value;
            OPT_DNS:    dns_in    = cmd_data.value;
            OPT_BCAST:  bcast_in  = cmd_data.value;
            OPT_SERVER: server_in = cmd_data.value;
            default:    ;
         endcase
      end

      rsp_data_in.status       = cmd_data.status;
      rsp_data_in.message_type = type_in;
      rsp_data_in.client_ip    = ip_in;
      rsp_data_in.server_ip    = server_in;
      rsp_data_in.subnet_mask  = mask_in;
      rsp_data_in.broadcast_ip = bcast_in;
      rsp_data_in.router_ip    = router_in;
      rsp_data_in.dns_ip       = dns_in;

      if (cmd_pop && cmd_data.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff        <= 32'd0;
         type_ff      <= TYPE_NONE;
         server_ff    <= 32'd0;
         mask_ff      <= 32'd0;
         bcast_ff     <= 32'd0;
         router_ff    <= 32'd0;
         dns_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_pop) begin
            ip_ff     <= ip_in;
            type_ff   <= type_in;
            server_ff <= server_in;
            mask_ff   <= mask_in;
            bcast_ff  <= bcast_in;
            router_ff <= router_in;
            dns_ff    <= dns_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_data.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
